// ===== hw/rtl/m3h_pkg.sv =====
`timescale 1ns / 1ps

package m3h_pkg;

  // mixing and finalizer constants
  localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2     = 32'h1b873593;
  localparam logic [31:0] STEP_ADD   = 32'he6546b64;
  localparam logic [31:0] FIN_M1     = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2     = 32'hc2b2ae35;
  localparam logic [31:0] SEED_RESET = 32'h9747b28c;

  // register map: index taken from paddr[2]
  localparam int unsigned PADDR_W  = 3;
  localparam logic        REG_SEED = 1'b0;

  localparam int unsigned QUEUE_DEPTH = 2;

  // what the back end does with one beat
  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,
    KIND_TAIL = 2'd1,
    KIND_FULL = 2'd2
  } kind_t;

  // classified beat handed from front to back
  typedef struct packed {
    logic [31:0] key;
    logic [2:0]  nbytes;
    kind_t       kind;
    logic        last;
  } item_t;

endpackage

// ===== hw/rtl/m3h_front.sv =====
`timescale 1ns / 1ps

module m3h_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         data_word,
  input  logic [2:0]          valid_bytes,
  input  logic                last,
  output logic                item_valid,
  input  logic                item_ready,
  output m3h_pkg::item_t      item
);

  logic           a_valid;
  logic [31:0]    a_key;
  logic [2:0]     a_nbytes;
  m3h_pkg::kind_t a_kind;
  logic           a_last;

  logic           b_valid;
  m3h_pkg::item_t b_item;

  logic           a_ready;
  logic           b_ready;
  logic [2:0]     nbytes;
  logic [31:0]    masked;
  m3h_pkg::kind_t kind;
  logic [31:0]    a_rot;

  // clamp count, classify, keep only valid bytes
  always_comb begin
    nbytes = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    unique case (nbytes)
      3'd0:    masked = 32'h0000_0000;
      3'd1:    masked = {24'd0, data_word[7:0]};
      3'd2:    masked = {16'd0, data_word[15:0]};
      3'd3:    masked = {8'd0, data_word[23:0]};
      default: masked = data_word;
    endcase
    if (nbytes == 3'd0) begin
      kind = m3h_pkg::KIND_SKIP;
    end else if (nbytes == 3'd4) begin
      kind = m3h_pkg::KIND_FULL;
    end else begin
      kind = m3h_pkg::KIND_TAIL;
    end
  end

  assign a_rot    = {a_key[16:0], a_key[31:17]};
  assign b_ready  = !b_valid || item_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
    end
    // first multiply
    if (a_ready && in_valid) begin
      a_key    <= masked * m3h_pkg::MIX_C1;
      a_nbytes <= nbytes;
      a_kind   <= kind;
      a_last   <= last;
    end
    // rotate by 15, second multiply
    if (b_ready && a_valid) begin
      b_item.key    <= a_rot * m3h_pkg::MIX_C2;
      b_item.nbytes <= a_nbytes;
      b_item.kind   <= a_kind;
      b_item.last   <= a_last;
    end
  end

  assign item_valid = b_valid;
  assign item       = b_item;

endmodule

// ===== hw/rtl/m3h_queue.sv =====
`timescale 1ns / 1ps

module m3h_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  m3h_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output m3h_pkg::item_t pop_item
);

  localparam int unsigned PTR_W = $clog2(m3h_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(m3h_pkg::QUEUE_DEPTH + 1);

  m3h_pkg::item_t slots [m3h_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(m3h_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(m3h_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(m3h_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/m3h_back.sv =====
`timescale 1ns / 1ps

module m3h_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [31:0]    seed,
  input  logic           item_valid,
  output logic           item_ready,
  input  m3h_pkg::item_t item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    hash_value
);

  logic        in_message;
  logic [31:0] running_hash;
  logic [31:0] byte_count;

  logic [31:0] h_base;
  logic [31:0] cnt_base;
  logic [31:0] hx;
  logic [31:0] hr;
  logic [31:0] h_next;
  logic [31:0] cnt_next;

  // finalizer pipeline
  logic        v0, v1, v2, v3;
  logic [31:0] f0, f1, f2, f3;
  logic        r0, r1, r2, r3;
  logic        pop;
  logic [31:0] f0_sh;
  logic [31:0] f1_sh;

  assign r3 = !v3 || out_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign r0 = !v0 || r1;
  assign item_ready = r0;
  assign pop = item_valid && r0;

  // hash recurrence
  always_comb begin
    h_base   = in_message ? running_hash : seed;
    cnt_base = in_message ? byte_count : 32'd0;
    hx       = h_base ^ item.key;
    hr       = {hx[18:0], hx[31:19]};
    unique case (item.kind)
      m3h_pkg::KIND_FULL: h_next = hr + {hr[29:0], 2'b00} + m3h_pkg::STEP_ADD;
      m3h_pkg::KIND_TAIL: h_next = hx;
      default:            h_next = h_base;
    endcase
    cnt_next = cnt_base + {29'd0, item.nbytes};
  end

  assign f0_sh = f0 ^ {16'd0, f0[31:16]};
  assign f1_sh = f1 ^ {13'd0, f1[31:13]};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (pop) begin
        in_message <= !item.last;
      end
      if (r0) begin
        v0 <= pop && item.last;
      end
      if (r1) begin
        v1 <= v0;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
    end
    if (pop) begin
      running_hash <= h_next;
      byte_count   <= cnt_next;
    end
    if (r0 && pop && item.last) begin
      f0 <= h_next ^ cnt_next;
    end
    if (r1 && v0) begin
      f1 <= f0_sh * m3h_pkg::FIN_M1;
    end
    if (r2 && v1) begin
      f2 <= f1_sh * m3h_pkg::FIN_M2;
    end
    if (r3 && v2) begin
      f3 <= f2 ^ {16'd0, f2[31:16]};
    end
  end

  assign out_valid  = v3;
  assign hash_value = f3;

endmodule

// ===== hw/rtl/murmur3_32_hash_stream.sv =====
`timescale 1ns / 1ps

// streaming murmurhash3 x86_32: one 32-bit little-endian word per beat, with
// a valid byte count (above four counts as four) and a last mark; the hash of
// the message comes out as one beat on the output channel after the last
// input beat. a word is taken every cycle as long as the output side keeps
// up; the loop-carried work (rotate, shift-add, add) is combinational in the
// back end, and the key mixing runs ahead in a two-stage multiply
// pipeline. out_valid rises once the last beat has passed the two front
// multiply stages, the queue, the hash update into the first finalizer
// register, then three more finalizer registers.
// the seed is read by the first beat of each message, so write it
// between messages. the seed register sits at byte address 0.
module murmur3_32_hash_stream (
  input  logic                         clk,
  input  logic                         rst,
  // apb-style config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [m3h_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input beats
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [31:0]                  data_word,
  input  logic [2:0]                   valid_bytes,
  input  logic                         last,
  // result beats
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [31:0]                  hash_value
);

  logic [31:0]    hash_seed;
  logic           cfg_write;

  // front to queue
  logic           f_valid;
  logic           f_ready;
  m3h_pkg::item_t f_item;

  // queue to back
  logic           q_valid;
  logic           q_ready;
  m3h_pkg::item_t q_item;

  // config register: word index is paddr[2], low bits ignored
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == m3h_pkg::REG_SEED) ? hash_seed : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= m3h_pkg::SEED_RESET;
    end else if (cfg_write && paddr[2] == m3h_pkg::REG_SEED) begin
      hash_seed <= pwdata;
    end
  end

  // clamp, mask and mix each word
  m3h_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_word   (data_word),
    .valid_bytes (valid_bytes),
    .last        (last),
    .item_valid  (f_valid),
    .item_ready  (f_ready),
    .item        (f_item)
  );

  // decouples the mixer from the hash update and finalizer
  m3h_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // running hash, byte count and finalizer
  m3h_back u_back (
    .clk        (clk),
    .rst        (rst),
    .seed       (hash_seed),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

endmodule

// ===== verif/murmur3_32_hash_stream_tb.sv =====
`timescale 1ns / 1ps

module murmur3_32_hash_stream_tb;

  // hash constants, written out here so that the check does not lean on the package
  localparam logic [31:0] KEY_MUL_A   = 32'hcc9e2d51;
  localparam logic [31:0] KEY_MUL_B   = 32'h1b873593;
  localparam logic [31:0] ROUND_ADD   = 32'he6546b64;
  localparam logic [31:0] AVAL_MUL_A  = 32'h85ebca6b;
  localparam logic [31:0] AVAL_MUL_B  = 32'hc2b2ae35;
  localparam logic [31:0] SEED_AT_RST = 32'h9747b28c;

  // seed register byte address, built from the register index
  localparam logic [m3h_pkg::PADDR_W-1:0] SEED_ADDR = {m3h_pkg::REG_SEED, 2'b00};

  // cycles to let pass once nothing is expected (pipeline is seven deep)
  localparam int SETTLE_CYCLES  = 12;
  // cycles with no beat moving on either side before the run is called dead
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_BEATS    = 232;

  // one input beat as it goes out on the wire
  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        is_last;
  } beat_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [m3h_pkg::PADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [31:0]                   data_word = '0;
  logic [2:0]                    valid_bytes = '0;
  logic                          last = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [31:0]                   hash_value;

  // beats waiting for the driver, and hashes waiting for the output side
  beat_t       pending_beats[$];
  logic [31:0] expected_hashes[$];

  // predictor state: seed register, hash so far, byte count, message open
  logic [31:0] seed_reg = SEED_AT_RST;
  logic [31:0] acc_hash = SEED_AT_RST;
  logic [31:0] acc_count = '0;
  logic        mid_message = 1'b0;

  int    beats_queued = 0;
  int    beats_sent = 0;
  int    beats_taken = 0;
  int    mismatches = 0;
  int    quiet_cycles = 0;
  // chance per cycle, in percent, that a side starts a stall burst
  int    in_idle_pct = 0;
  int    out_idle_pct = 0;
  int    in_gap = 0;
  int    out_gap = 0;
  beat_t next_beat;
  logic [31:0] want_hash;

  murmur3_32_hash_stream uut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_word   (data_word),
    .valid_bytes (valid_bytes),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hash_value  (hash_value)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // hash predictor
  // ---------------------------------------------------------------------

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // per-word key scramble: multiply, rotate 15, multiply
  function automatic logic [31:0] scramble_key(input logic [31:0] k);
    logic [31:0] t;
    t = k * KEY_MUL_A;
    t = rotl32(t, 15);
    t = t * KEY_MUL_B;
    return t;
  endfunction

  // avalanche finalizer
  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * AVAL_MUL_A;
    t = t ^ (t >> 13);
    t = t * AVAL_MUL_B;
    t = t ^ (t >> 16);
    return t;
  endfunction

  // fold one accepted beat into the running hash; a last beat yields a hash
  task automatic fold_beat_into_hash(input logic [31:0] word, input logic [2:0] nb_in,
                                     input logic is_last);
    logic [31:0] h;
    logic [31:0] cnt;
    logic [31:0] mask;
    int          nb;
    nb = (nb_in > 3'd4) ? 4 : int'(nb_in);
    // a new message starts from the seed and a zero count
    if (mid_message) begin
      h = acc_hash;
      cnt = acc_count;
    end else begin
      h = seed_reg;
      cnt = '0;
    end
    if (nb == 4) begin
      h = h ^ scramble_key(word);
      h = rotl32(h, 13) * 32'd5 + ROUND_ADD;
    end else if (nb != 0) begin
      // tail: bytes above the count are dropped, no rotate-multiply-add
      mask = (32'h1 << (8 * nb)) - 32'h1;
      h = h ^ scramble_key(word & mask);
    end
    cnt = cnt + nb;
    if (is_last) begin
      expected_hashes.push_back(avalanche(h ^ cnt));
      acc_hash = seed_reg;
      acc_count = '0;
      mid_message = 1'b0;
    end else begin
      acc_hash = h;
      acc_count = cnt;
      mid_message = 1'b1;
    end
  endtask

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // input driver: beats change on the falling edge
  // ---------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && beats_taken != beats_sent) begin
      // beat still on the wire, hold it
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap = in_gap - 1;
    end else if (pending_beats.size() != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      // start of a stall burst, this cycle included
      in_valid <= 1'b0;
      in_gap = $urandom_range(0, 13);
    end else if (pending_beats.size() != 0) begin
      next_beat = pending_beats.pop_front();
      in_valid <= 1'b1;
      data_word <= next_beat.word;
      valid_bytes <= next_beat.nbytes;
      last <= next_beat.is_last;
      beats_sent++;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output back-pressure in bursts
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap = out_gap - 1;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      out_ready <= 1'b0;
      out_gap = $urandom_range(0, 13);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // monitor: both channels sampled on the rising edge
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (in_valid && in_ready) begin
        fold_beat_into_hash(data_word, valid_bytes, last);
        beats_taken++;
        quiet_cycles = 0;
      end
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        if (expected_hashes.size() == 0) begin
          note_mismatch($sformatf("hash beat %h with none expected", hash_value));
        end else begin
          want_hash = expected_hashes.pop_front();
          if (hash_value !== want_hash)
            note_mismatch($sformatf("hash_value %h, expected %h", hash_value, want_hash));
        end
      end
    end
  end

  // watchdog: nothing moving for too long means the block hung
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  task automatic queue_beat(input logic [31:0] word, input logic [2:0] nb,
                            input logic is_last);
    beat_t b;
    b.word = word;
    b.nbytes = nb;
    b.is_last = is_last;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // one apb transfer, setup then access; pready is honored though tied high
  task automatic apb_transfer(input logic wr, input logic [m3h_pkg::PADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_seed_readback();
    logic [31:0] rd;
    apb_transfer(1'b0, SEED_ADDR, '0, rd);
    if (rd !== seed_reg)
      note_mismatch($sformatf("seed reads %h, expected %h", rd, seed_reg));
  endtask

  // only called while idle, so the predictor can take the new seed at once
  task automatic write_seed(input logic [31:0] val);
    logic [31:0] unused;
    apb_transfer(1'b1, SEED_ADDR, val, unused);
    seed_reg = val;
    if (!mid_message) acc_hash = val;
    check_seed_readback();
  endtask

  // sender pauses until every beat is in and every hash is out
  task automatic wait_idle();
    while (beats_taken != beats_queued || expected_hashes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // random message, closed with a last beat so a phase always ends idle
  task automatic queue_random_message();
    int kind;
    int nfull;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      // well-formed: full words then a tail of 0..4 bytes
      nfull = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      repeat (nfull) queue_beat($urandom, 3'd4, 1'b0);
      queue_beat($urandom, 3'($urandom_range(0, 4)), 1'b1);
    end else begin
      // noise: any count mid-message, zero and partial beats, oversized counts
      nfull = $urandom_range(0, 6);
      repeat (nfull) queue_beat($urandom, 3'($urandom_range(0, 7)), 1'b0);
      queue_beat($urandom, 3'($urandom_range(0, 7)), 1'b1);
    end
  endtask

  task automatic run_random_phase(input int budget);
    int start;
    start = beats_queued;
    while (beats_queued - start < budget) queue_random_message();
  endtask

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset value of the seed
    check_seed_readback();

    // directed beats under the reset seed, light idling
    in_idle_pct = 10;
    out_idle_pct = 10;
    queue_beat(32'h0000_0000, 3'd0, 1'b1);     // empty message
    queue_beat(32'h0000_0000, 3'd4, 1'b1);
    queue_beat(32'hffff_ffff, 3'd4, 1'b1);
    queue_beat(32'hffff_ff5a, 3'd1, 1'b1);     // one byte tail, junk above
    queue_beat(32'ha5a5_c3e1, 3'd2, 1'b1);
    queue_beat(32'hffff_ffff, 3'd3, 1'b1);
    queue_beat(32'h1234_5678, 3'd5, 1'b1);     // counts above four act as four
    queue_beat(32'h8765_4321, 3'd6, 1'b1);
    queue_beat(32'hffff_ffff, 3'd7, 1'b1);
    // zero-byte beat in the middle of a message
    queue_beat(32'hdead_beef, 3'd4, 1'b0);
    queue_beat(32'hffff_ffff, 3'd0, 1'b0);
    queue_beat(32'h0102_0304, 3'd4, 1'b0);
    queue_beat(32'hffff_ffff, 3'd3, 1'b1);
    // partial beat without last, message goes on
    queue_beat(32'hcafe_f00d, 3'd2, 1'b0);
    queue_beat(32'h1357_9bdf, 3'd4, 1'b0);
    queue_beat(32'h0000_0000, 3'd0, 1'b1);
    // longer message of full words
    repeat (5) queue_beat($urandom, 3'd4, 1'b0);
    queue_beat($urandom, 3'd4, 1'b1);
    wait_idle();

    // seed of zero, heavy idling on both sides
    write_seed(32'h0000_0000);
    in_idle_pct = 30;
    out_idle_pct = 30;
    run_random_phase(PHASE_BEATS);
    wait_idle();

    // all-ones seed, output side stalls only
    write_seed(32'hffff_ffff);
    in_idle_pct = 0;
    out_idle_pct = 25;
    run_random_phase(PHASE_BEATS);
    wait_idle();

    // random seed, input side gaps only
    write_seed($urandom);
    in_idle_pct = 20;
    out_idle_pct = 0;
    run_random_phase(PHASE_BEATS);
    wait_idle();

    // back to the reset seed, no idling in the last stretch
    write_seed(SEED_AT_RST);
    in_idle_pct = 0;
    out_idle_pct = 0;
    run_random_phase(PHASE_BEATS);
    wait_idle();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
